### hw/rtl/vrib_pkg.sv
// ----------------------------------------------------------------------------
// vrib_pkg
// shared codes and result type for the varint record index builder
// ----------------------------------------------------------------------------
`default_nettype none

package vrib_pkg;

  typedef enum logic [1:0] {
    EV_RECORD   = 2'd0,
    EV_EMPTY    = 2'd1,
    EV_TRUNC    = 2'd2,
    EV_TOO_LONG = 2'd3
  } event_e;

  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_LEN     = 2'd1;
  localparam logic [1:0] PH_PAYLOAD = 2'd2;
  localparam logic [1:0] PH_DONE    = 2'd3;

  localparam int          VarintMaxBytes = 5;
  localparam logic [6:0]  VarintDataMask = 7'h7F;

  typedef struct packed {
    event_e      ev;
    logic [31:0] idx;
    logic [31:0] off;
    logic [31:0] len;
    logic        fin;
  } res_t;

endpackage

`default_nettype wire

### hw/rtl/varint_record_index_builder.sv
// ----------------------------------------------------------------------------
// varint_record_index_builder
// parses a length-prefixed varint record pool one byte per beat and reports
// index, start offset and length of each record, or an error event
// ----------------------------------------------------------------------------
// a byte reaches its result beat through two registers: input register, result reg
// throughput: one byte per cycle, from a combinational parse state update, while no
// result beat is held by the result stream; a byte that yields no result advances even while a result beat waits
// reset: parse state back to the header phase, counters zero, pool_bytes zero
// reset is asynchronous active low, no clearing pass
// ----------------------------------------------------------------------------
`default_nettype none

module varint_record_index_builder #(
  parameter int OFFSET_BITS = 32
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  // config write channel
  input  wire logic         cfg_valid_i,
  output logic              cfg_ready_o,
  input  wire logic [31:0]  cfg_data_i,     // pool_bytes
  // input stream
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] data_byte
  input  wire logic         s_axis_tuser,   // [0] start_req
  // result stream
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  output logic [95:0]       m_axis_tdata,   // [31:0] record_index, [63:32] record_offset,
                                            // [95:64] record_length
  output logic [1:0]        m_axis_tuser,   // [1:0] event_res
  output logic              m_axis_tlast    // final_record
);
  import vrib_pkg::*;

  localparam int OB = OFFSET_BITS;
  localparam int LW = (OB > 32) ? OB : 32;
  localparam int SW = LW + 1;

  // config
  logic [31:0] pool_q;

  // parse state
  logic [1:0]    phase_q, phase_d;
  logic [31:0]   acc_q, acc_d;
  logic [2:0]    vb_q, vb_d;
  logic [OB-1:0] off_q, off_d;
  logic [31:0]   rexp_q, rexp_d;
  logic [31:0]   rseen_q, rseen_d;
  logic [31:0]   pleft_q, pleft_d;
  logic [OB-1:0] rstart_q, rstart_d;

  // input register
  logic       in_vld_q;
  logic [7:0] in_byte_q;
  logic       in_start_q;

  // result register
  logic out_vld_q;
  res_t out_q;

  logic    adv;
  logic    has_res;
  res_t    res;
  logic [OB-1:0] lim;
  logic [LW-1:0] lim_w;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    logic [LW-1:0] pool_ext;
    logic [LW-1:0] cap_ext;
    pool_ext = LW'(pool_q);
    cap_ext  = LW'({OB{1'b1}});
    lim_w    = (pool_ext < cap_ext) ? pool_ext : cap_ext;
    lim      = lim_w[OB-1:0];
  end

  always_comb begin
    logic [1:0]    ph;
    logic [31:0]   acc;
    logic [2:0]    vb;
    logic [OB-1:0] off;
    logic [31:0]   rexp;
    logic [31:0]   rseen;
    logic [31:0]   pleft;
    logic [OB-1:0] rstart;
    logic [OB-1:0] off_n;
    logic [31:0]   acc_n;
    logic [2:0]    vb_n;
    logic [31:0]   pl;
    logic [31:0]   rseen_n;
    logic [5:0]    shamt;
    logic [SW-1:0] end_pos;
    logic          fin;

    if (in_start_q) begin
      ph = PH_HEADER; acc = '0; vb = '0; off = '0;
      rexp = '0; rseen = '0; pleft = '0; rstart = '0;
    end else begin
      ph = phase_q; acc = acc_q; vb = vb_q; off = off_q;
      rexp = rexp_q; rseen = rseen_q; pleft = pleft_q; rstart = rstart_q;
    end

    phase_d  = ph;
    acc_d    = acc;
    vb_d     = vb;
    off_d    = off;
    rexp_d   = rexp;
    rseen_d  = rseen;
    pleft_d  = pleft;
    rstart_d = rstart;

    has_res  = 1'b0;
    res      = '{ev: EV_RECORD, idx: '0, off: '0, len: '0, fin: 1'b0};

    off_n    = off + OB'(1);
    shamt    = 6'(vb) * 6'd7;
    acc_n    = acc | (32'(in_byte_q[6:0] & VarintDataMask) << shamt);
    vb_n     = vb + 3'd1;
    pl       = (pleft != '0) ? pleft - 32'd1 : '0;
    rseen_n  = rseen + 32'd1;
    end_pos  = SW'(off_n) + SW'(acc_n);
    fin      = ({1'b0, rseen} + 33'd1) == {1'b0, rexp};

    if (ph == PH_DONE) begin
      has_res = 1'b0;
    end else if (off >= lim) begin
      has_res = 1'b1;
      phase_d = PH_DONE;
      if (ph == PH_HEADER) begin
        if (acc == '0) begin
          res.ev = EV_EMPTY;
        end else begin
          res.ev  = EV_TRUNC;
          res.off = 32'(off);
        end
      end else begin
        res.ev  = EV_TRUNC;
        res.idx = rseen;
        res.off = 32'(rstart);
        res.len = acc;
      end
    end else begin
      off_d = off_n;
      if (ph == PH_PAYLOAD) begin
        pleft_d = pl;
        if (pl == '0) begin
          rseen_d = rseen_n;
          if (rseen_n >= rexp) begin
            phase_d = PH_DONE;
          end else if (off_n >= lim) begin
            has_res = 1'b1;
            phase_d = PH_DONE;
            res.ev  = EV_TRUNC;
            res.idx = rseen_n;
            res.off = 32'(off_n);
          end else begin
            phase_d  = PH_LEN;
            rstart_d = off_n;
            acc_d    = '0;
            vb_d     = '0;
          end
        end
      end else begin
        acc_d = acc_n;
        vb_d  = vb_n;
        if (in_byte_q[7] && (int'(vb_n) >= VarintMaxBytes)) begin
          has_res = 1'b1;
          phase_d = PH_DONE;
          res.ev  = EV_TOO_LONG;
          res.len = acc_n;
          if (ph != PH_HEADER) begin
            res.idx = rseen;
            res.off = 32'(rstart);
          end
        end else if (in_byte_q[7] && (off_n < lim)) begin
          has_res = 1'b0;
        end else if (ph == PH_HEADER) begin
          rexp_d = acc_n;
          if (acc_n == '0) begin
            has_res = 1'b1;
            phase_d = PH_DONE;
            res.ev  = EV_EMPTY;
          end else if (off_n >= lim) begin
            has_res = 1'b1;
            phase_d = PH_DONE;
            res.ev  = EV_TRUNC;
            res.off = 32'(off_n);
          end else begin
            phase_d  = PH_LEN;
            rstart_d = off_n;
            acc_d    = '0;
            vb_d     = '0;
          end
        end else begin
          has_res = 1'b1;
          res.idx = rseen;
          res.off = 32'(rstart);
          res.len = acc_n;
          if (end_pos > SW'(lim)) begin
            res.ev  = EV_TRUNC;
            phase_d = PH_DONE;
          end else begin
            res.ev  = EV_RECORD;
            res.fin = fin;
            if (acc_n != '0) begin
              phase_d = PH_PAYLOAD;
              pleft_d = acc_n;
            end else begin
              rseen_d = rseen_n;
              if (rseen_n >= rexp) begin
                phase_d = PH_DONE;
              end else begin
                phase_d  = PH_LEN;
                rstart_d = off_n;
                acc_d    = '0;
                vb_d     = '0;
              end
            end
          end
        end
      end
    end
  end

  assign adv           = in_vld_q && (!has_res || !out_vld_q || m_axis_tready);
  assign s_axis_tready = !in_vld_q || adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pool_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      pool_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_HEADER;
      acc_q    <= '0;
      vb_q     <= '0;
      off_q    <= '0;
      rexp_q   <= '0;
      rseen_q  <= '0;
      pleft_q  <= '0;
      rstart_q <= '0;
    end else if (adv) begin
      phase_q  <= phase_d;
      acc_q    <= acc_d;
      vb_q     <= vb_d;
      off_q    <= off_d;
      rexp_q   <= rexp_d;
      rseen_q  <= rseen_d;
      pleft_q  <= pleft_d;
      rstart_q <= rstart_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_vld_q <= 1'b1;
    end else if (adv) begin
      in_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte_q  <= s_axis_tdata;
      in_start_q <= s_axis_tuser;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv && has_res) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && has_res) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {out_q.len, out_q.off, out_q.idx};
  assign m_axis_tuser  = out_q.ev;
  assign m_axis_tlast  = out_q.fin;

  // final flag only on a found record
  a_fin_only_record: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tuser == EV_RECORD)
    else $error("final_record on a non-record event");

  // an error event ends the parse
  a_err_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && has_res && (res.ev != EV_RECORD) |=> phase_q == PH_DONE)
    else $error("parse not idle after error event");

  // idle holds until a restart beat is consumed
  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_DONE) && !(adv && in_start_q) |=> phase_q == PH_DONE)
    else $error("left idle without restart");

  // record count never passes the announced count
  a_seen_le_exp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rseen_q <= rexp_q)
    else $error("records seen beyond header count");

  // a varint byte count of five only outside the varint phases
  a_vb_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(vb_q) < VarintMaxBytes) ||
    ((phase_q != PH_HEADER) && (phase_q != PH_LEN)))
    else $error("varint byte count out of range");

endmodule

`default_nettype wire

### sim/vrib_record_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vrib_record_monitor
// watches the config, byte and result channels of the varint record index
// builder, tracks the parse on every accepted byte and compares each result
// beat field by field with the oldest predicted event
// ----------------------------------------------------------------------------

module vrib_record_monitor
  import vrib_pkg::*;
#(
  parameter int OFFSET_BITS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [31:0] cfg_data_i,   // pool_bytes
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  logic [7:0]  in_data_i,    // [7:0] data_byte
  input  logic        in_user_i,    // [0] start_req
  input  logic        res_valid_i,
  input  logic        res_ready_i,
  input  logic [95:0] res_data_i,   // [31:0] record_index, [63:32] record_offset,
                                    // [95:64] record_length
  input  logic [1:0]  res_user_i,   // [1:0] event_res
  input  logic        res_last_i,   // final_record
  output int          mismatches_o,
  output int          pending_o,
  output int          compared_o
);

  localparam logic [63:0] PoolCap    = (64'd1 << OFFSET_BITS) - 64'd1;
  localparam logic [63:0] OffsetMask = (64'd1 << (OFFSET_BITS + 1)) - 64'd1;
  localparam logic [63:0] WordMask   = 64'hFFFF_FFFF;

  logic [1:0]  parse_phase;
  logic [63:0] pool_len;
  logic [63:0] accum;
  logic [63:0] offset;
  logic [63:0] rec_expected;
  logic [63:0] rec_seen;
  logic [63:0] pay_left;
  logic [63:0] rec_start;
  int unsigned vbytes;
  res_t        event_q[$];
  int          mismatch_cnt;
  int          compare_cnt;

  function automatic void clear_parse();
    parse_phase  = PH_HEADER;
    accum        = '0;
    vbytes       = 0;
    offset       = '0;
    rec_expected = '0;
    rec_seen     = '0;
    pay_left     = '0;
    rec_start    = '0;
  endfunction

  function automatic void open_record();
    parse_phase = PH_LEN;
    rec_start   = offset;
    accum       = '0;
    vbytes      = 0;
  endfunction

  // any event but a found record ends the parse until the next start
  function automatic res_t make_res(input event_e ev, input logic [63:0] idx,
                                    input logic [63:0] offs, input logic [63:0] len,
                                    input logic fin);
    res_t r;
    r.ev  = ev;
    r.idx = idx[31:0];
    r.off = offs[31:0];
    r.len = len[31:0];
    r.fin = fin;
    if (ev != EV_RECORD) parse_phase = PH_DONE;
    return r;
  endfunction

  function automatic bit parse_byte(input logic [7:0] b, input logic st, output res_t r);
    logic [63:0] lim;
    logic [63:0] len;
    logic [63:0] idx;
    r = '0;
    if (st) clear_parse();
    lim = (pool_len < PoolCap) ? pool_len : PoolCap;
    if (parse_phase == PH_DONE) return 0;

    if (offset >= lim) begin
      if (parse_phase == PH_HEADER) begin
        if (accum == 0) r = make_res(EV_EMPTY, 0, 0, 0, 1'b0);
        else r = make_res(EV_TRUNC, 0, offset, 0, 1'b0);
        return 1;
      end
      r = make_res(EV_TRUNC, rec_seen, rec_start, accum, 1'b0);
      return 1;
    end
    offset = (offset + 64'd1) & OffsetMask;

    if (parse_phase == PH_PAYLOAD) begin
      if (pay_left > 0) pay_left = pay_left - 64'd1;
      if (pay_left > 0) return 0;
      rec_seen = rec_seen + 64'd1;
      if (rec_seen >= rec_expected) begin
        parse_phase = PH_DONE;
        return 0;
      end
      if (offset >= lim) begin
        r = make_res(EV_TRUNC, rec_seen, offset, 0, 1'b0);
        return 1;
      end
      open_record();
      return 0;
    end

    // header count or record length varint
    if (vbytes < VarintMaxBytes)
      accum = (accum | (64'(b[6:0] & VarintDataMask) << (7 * vbytes))) & WordMask;
    vbytes++;
    if (b[7]) begin
      if (vbytes >= VarintMaxBytes) begin
        if (parse_phase == PH_HEADER) r = make_res(EV_TOO_LONG, 0, 0, accum, 1'b0);
        else r = make_res(EV_TOO_LONG, rec_seen, rec_start, accum, 1'b0);
        return 1;
      end
      if (offset < lim) return 0;
    end

    if (parse_phase == PH_HEADER) begin
      rec_expected = accum;
      if (rec_expected == 0) begin
        r = make_res(EV_EMPTY, 0, 0, 0, 1'b0);
        return 1;
      end
      if (offset >= lim) begin
        r = make_res(EV_TRUNC, 0, offset, 0, 1'b0);
        return 1;
      end
      open_record();
      return 0;
    end

    len = accum;
    idx = rec_seen;
    if (offset + len > lim) begin
      r = make_res(EV_TRUNC, idx, rec_start, len, 1'b0);
      return 1;
    end
    r = make_res(EV_RECORD, idx, rec_start, len, (idx + 64'd1) == rec_expected);
    if (len > 0) begin
      parse_phase = PH_PAYLOAD;
      pay_left    = len;
    end else begin
      rec_seen = rec_seen + 64'd1;
      if (rec_seen >= rec_expected) parse_phase = PH_DONE;
      else open_record();
    end
    return 1;
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    res_t got;
    res_t fresh;
    if (!rst_ni) begin
      pool_len = '0;
      clear_parse();
      event_q.delete();
      mismatch_cnt = 0;
      compare_cnt  = 0;
    end else begin
      if (res_valid_i && res_ready_i) begin
        got.ev  = event_e'(res_user_i);
        got.idx = res_data_i[31:0];
        got.off = res_data_i[63:32];
        got.len = res_data_i[95:64];
        got.fin = res_last_i;
        if (event_q.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10)
            $display("%0t unexpected result beat: ev=%0d idx=%0d off=%0d len=%0d last=%0b",
                     $time, got.ev, got.idx, got.off, got.len, got.fin);
        end else begin
          want = event_q.pop_front();
          compare_cnt++;
          if (want.ev !== got.ev || want.idx !== got.idx || want.off !== got.off ||
              want.len !== got.len || want.fin !== got.fin) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10)
              $display("%0t mismatch: expected ev=%0d idx=%0d off=%0d len=%0d last=%0b, %s",
                       $time, want.ev, want.idx, want.off, want.len, want.fin,
                       $sformatf("got ev=%0d idx=%0d off=%0d len=%0d last=%0b",
                                 got.ev, got.idx, got.off, got.len, got.fin));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) pool_len = {32'd0, cfg_data_i};
      if (in_valid_i && in_ready_i) begin
        if (parse_byte(in_data_i, in_user_i, fresh)) event_q = {event_q, fresh};
      end
    end
    mismatches_o <= mismatch_cnt;
    pending_o    <= event_q.size();
    compared_o   <= compare_cnt;
  end

endmodule

### sim/varint_record_index_builder_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// varint_record_index_builder_test
// drives serialized pools through the record index builder under several
// pool sizes and backpressure patterns; a separate monitor predicts and
// checks every result beat, this module makes stimulus and gives the verdict
// ----------------------------------------------------------------------------

module varint_record_index_builder_test;
  import vrib_pkg::*;

  logic        clk_i;
  logic        rst_ni        = 1'b0;
  logic        cfg_valid_i   = 1'b0;
  logic [31:0] cfg_data_i    = '0;
  logic        cfg_ready_o;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [7:0] data_byte
  logic        s_axis_tuser  = 1'b0; // [0] start_req
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [95:0] m_axis_tdata;         // [31:0] record_index, [63:32] record_offset,
                                     // [95:64] record_length
  logic [1:0]  m_axis_tuser;         // [1:0] event_res
  logic        m_axis_tlast;         // final_record

  int          mismatches;
  int          pending;
  int          compared;
  int          send_idle_pct = 0;
  int          stall_pct     = 0;
  logic        hold_go       = 1'b0;
  int          hold_left     = 0;
  logic [7:0]  pool_q[$];
  int          bytes_sent    = 0;
  int          pools_sent    = 0;
  int          sizes_used    = 0;

  varint_record_index_builder #(
    .OFFSET_BITS (32)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  vrib_record_monitor #(
    .OFFSET_BITS (32)
  ) record_mon (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_i   (s_axis_tready),
    .in_data_i    (s_axis_tdata),
    .in_user_i    (s_axis_tuser),
    .res_valid_i  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_data_i   (m_axis_tdata),
    .res_user_i   (m_axis_tuser),
    .res_last_i   (m_axis_tlast),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .compared_o   (compared)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("timeout with %0d results outstanding", pending);
    $display("varint_record_index_builder regression: fail");
    $finish;
  end

  // result side: random stalls, or a long hold-off on request
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      hold_left     <= hold_left - 1;
      m_axis_tready <= 1'b0;
    end else if (hold_go) begin
      hold_left     <= 250;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  task automatic send_beat(input logic [7:0] b, input logic st);
    if ($urandom_range(0, 99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(0, 99) < send_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= st;
    do @(posedge clk_i); while (!s_axis_tready);
    bytes_sent++;
  endtask

  task automatic send_pool();
    foreach (pool_q[i]) send_beat(pool_q[i], i == 0);
    pools_sent++;
  endtask

  // only while idle: no results owed and the pipeline flushed
  task automatic set_pool_size(input logic [31:0] v);
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (8) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sizes_used++;
  endtask

  task automatic put_varint(input logic [31:0] v);
    do begin
      pool_q = {pool_q, {v > 32'd127, v[6:0]}};
      v = v >> 7;
    end while (v != 0);
  endtask

  function automatic logic [31:0] pick_length();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, 4);
    if (r < 18) return $urandom_range(5, 12);
    if (r == 18) return $urandom_range(128, 140);
    return $urandom();
  endfunction

  task automatic put_records();
    int announced;
    int present;
    logic [31:0] len;
    announced = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
    present   = announced;
    if ($urandom_range(0, 19) == 0) announced = $urandom_range(128, 200);
    put_varint(announced);
    repeat (present) begin
      len = pick_length();
      put_varint(len);
      if (len < 32'd256) repeat (len) pool_q = {pool_q, 8'($urandom_range(0, 255))};
    end
  endtask

  task automatic build_pool();
    int kind;
    int sub;
    pool_q.delete();
    kind = $urandom_range(0, 9);
    if (kind < 7) begin
      put_records();
      // stray bytes after the pool is done
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 2)) pool_q = {pool_q, 8'($urandom_range(0, 255))};
    end else if (kind < 9) begin
      sub = $urandom_range(0, 2);
      if (sub == 0) begin
        if ($urandom_range(0, 1)) put_varint($urandom_range(1, 3));
        repeat ($urandom_range(5, 6))
          pool_q = {pool_q, {1'b1, 7'($urandom_range(0, 127))}};
      end else if (sub == 1) begin
        put_varint($urandom_range(1, 3));
        repeat (4) pool_q = {pool_q, {1'b1, 7'($urandom_range(0, 127))}};
        pool_q = {pool_q, {1'b0, 7'($urandom_range(0, 127))}};
      end else begin
        put_records();
        repeat ($urandom_range(0, pool_q.size() - 1)) pool_q = pool_q[0:$-1];
      end
    end else begin
      repeat ($urandom_range(1, 8)) pool_q = {pool_q, 8'($urandom_range(0, 255))};
    end
  endtask

  initial begin
    logic [31:0] size;
    int          budget;
    int          target;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin size = 32'hFFFF_FFFF; send_idle_pct = 0;  stall_pct <= 0;  budget = 90;  end
        1: begin size = 32'd0;         send_idle_pct = 85; stall_pct <= 0;  budget = 35;  end
        2: begin
          size = $urandom_range(4, 24); send_idle_pct = 0; stall_pct <= 85; budget = 120;
        end
        3: begin
          size = $urandom_range(1, 40); send_idle_pct = 24; stall_pct <= 24; budget = 120;
        end
        4: begin size = 32'h8000_0000; send_idle_pct = 0;  stall_pct <= 0;  budget = 90;  end
        default: begin
          size = 32'd1; send_idle_pct = 24; stall_pct <= 24; budget = 35;
        end
      endcase
      set_pool_size(size);

      if (ph == 0) begin
        // empty pool, single empty record, over-long header, ignored byte,
        // huge length, two records, over-long record length
        pool_q = '{8'h00};
        send_pool();
        pool_q = '{8'h01, 8'h00};
        send_pool();
        pool_q = '{8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_pool();
        send_beat(8'h55, 1'b0);
        pool_q = '{8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h0F};
        send_pool();
        pool_q = '{8'h02, 8'h01, 8'hAA, 8'h00};
        send_pool();
        pool_q = '{8'h01, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80};
        send_pool();
      end

      // keep offering bytes while the result side is held off
      if (ph == 4) begin
        hold_go <= 1'b1;
        @(posedge clk_i);
        hold_go <= 1'b0;
      end

      target = bytes_sent + budget;
      while (bytes_sent < target) begin
        build_pool();
        send_pool();
      end
    end

    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (10) @(posedge clk_i);

    $display("covered %0d pool bytes in %0d pools over %0d pool size settings",
             bytes_sent, pools_sent, sizes_used);
    $display("%0d result beats compared, with idle, stall and hold-off phases", compared);
    if (mismatches == 0 && pending == 0) begin
      $display("varint_record_index_builder regression: pass");
    end else begin
      $display("varint_record_index_builder regression: fail");
    end
    $finish;
  end

endmodule

### varint_record_index_builder.f
hw/rtl/vrib_pkg.sv
hw/rtl/varint_record_index_builder.sv
sim/vrib_record_monitor.sv
sim/varint_record_index_builder_test.sv
